/* rtl/core/ftwa_pkg.sv */
// Shared types, codes and constants for the flow table with aging.
package ftwa_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam logic [16:0] IDLE_TIMEOUT_RESET = 17'd300;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;

  localparam logic [1:0] STATUS_HIT   = 2'd0;
  localparam logic [1:0] STATUS_NEW   = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_SWEPT = 2'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_index;
    logic [31:0] msg_total;
    logic [7:0]  active_count;
    logic [7:0]  removed_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] seen_at;
    logic [31:0] msg_count;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;
    logic pend;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/core/ftwa_ctrl.sv */
// Sequencer for the flow table: load an item, walk the table, post the result.
module ftwa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ftwa_pkg::dp_stat_t stat,
  output ftwa_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        // stop on a hit, or once every issued read has been evaluated
        if (stat.hit || (!stat.more && !stat.pend)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/ftwa_dp.sv */
// Datapath: entry memory, walk pointers, match and age test, result register.
module ftwa_dp #(
  parameter int unsigned TABLE_DEPTH = ftwa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ftwa_pkg::in_item_t  in_data,
  input  logic                cfg_wr_en,
  input  logic [16:0]         cfg_wr_data,
  input  ftwa_pkg::ctl_cmd_t  cmd,
  output ftwa_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output ftwa_pkg::out_item_t out_data
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  ftwa_pkg::entry_t mem [TABLE_DEPTH];

  ftwa_pkg::in_item_t item;
  ftwa_pkg::entry_t   rd_data;
  logic               rd_vld;
  logic [CW-1:0]      rd_ptr;
  logic [CW-1:0]      cmp_ptr;
  logic [CW-1:0]      wr_ptr;
  logic [CW-1:0]      occupied;
  logic [CW-1:0]      removed;
  logic [16:0]        idle_timeout;
  logic               found;
  logic [CW-1:0]      found_idx;
  logic [31:0]        found_cnt;

  logic               is_lookup;
  logic               match;
  logic [31:0]        idle;
  logic               expired;
  logic               walk_eval;
  logic               hit;
  logic               keep;
  logic               room;
  logic               issue;
  logic [31:0]        upd_cnt;
  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  ftwa_pkg::entry_t   mem_wd;
  logic [31:0]        found_idx_ext;
  logic [31:0]        occ_ext;
  logic [31:0]        occ_inc_ext;
  logic [31:0]        wr_ext;
  logic [31:0]        removed_ext;
  ftwa_pkg::out_item_t out_next;

  assign is_lookup = (item.command == ftwa_pkg::CMD_LOOKUP);
  assign match     = (rd_data.ip == item.client_ip) && (rd_data.port == item.client_port);
  assign idle      = item.now_seconds - rd_data.seen_at;
  assign expired   = idle > 32'(idle_timeout);
  assign walk_eval = cmd.walk && rd_vld;
  assign hit       = walk_eval && is_lookup && match;
  assign keep      = walk_eval && !is_lookup && !expired;
  assign room      = occupied < CW'(TABLE_DEPTH);
  assign issue     = cmd.walk && (rd_ptr < occupied);
  assign upd_cnt   = (rd_data.msg_count == 32'hFFFF_FFFF) ? rd_data.msg_count
                                                          : rd_data.msg_count + 32'd1;

  assign stat.more     = rd_ptr < occupied;
  assign stat.pend     = rd_vld;
  assign stat.hit      = hit;
  assign stat.out_free = !out_valid || out_ready;

  // One write port: hit refresh, sweep compaction, or append at finish
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cmp_ptr[IW-1:0];
    mem_wd = rd_data;
    priority if (hit) begin
      mem_we           = 1'b1;
      mem_wa           = cmp_ptr[IW-1:0];
      mem_wd.seen_at   = item.now_seconds;
      mem_wd.msg_count = upd_cnt;
    end else if (keep && (wr_ptr != cmp_ptr)) begin
      mem_we = 1'b1;
      mem_wa = wr_ptr[IW-1:0];
    end else if (cmd.finish && is_lookup && !found && room) begin
      mem_we           = 1'b1;
      mem_wa           = occupied[IW-1:0];
      mem_wd.ip        = item.client_ip;
      mem_wd.port      = item.client_port;
      mem_wd.seen_at   = item.now_seconds;
      mem_wd.msg_count = 32'd1;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_ptr[IW-1:0]];
      cmp_ptr <= rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld       <= 1'b0;
      occupied     <= '0;
      idle_timeout <= ftwa_pkg::IDLE_TIMEOUT_RESET;
      found        <= 1'b0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      removed      <= '0;
    end else begin
      if (cfg_wr_en) begin
        idle_timeout <= cfg_wr_data;
      end
      rd_vld <= issue;
      if (cmd.load) begin
        rd_ptr  <= '0;
        wr_ptr  <= '0;
        removed <= '0;
        found   <= 1'b0;
      end else begin
        if (issue) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        if (keep) begin
          wr_ptr <= wr_ptr + CW'(1);
        end
        if (walk_eval && !is_lookup && expired) begin
          removed <= removed + CW'(1);
        end
        if (hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (!is_lookup) begin
          occupied <= wr_ptr;
        end else if (!found && room) begin
          occupied <= occupied + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (hit) begin
      found_idx <= cmp_ptr;
      found_cnt <= upd_cnt;
    end
  end

  assign found_idx_ext = 32'(found_idx);
  assign occ_ext       = 32'(occupied);
  assign occ_inc_ext   = 32'(occupied) + 32'd1;
  assign wr_ext        = 32'(wr_ptr);
  assign removed_ext   = 32'(removed);

  // Build the result from the walk outcome
  always_comb begin
    out_next = '0;
    priority if (!is_lookup) begin
      out_next.status        = ftwa_pkg::STATUS_SWEPT;
      out_next.active_count  = wr_ext[7:0];
      out_next.removed_count = removed_ext[7:0];
    end else if (found) begin
      out_next.status        = ftwa_pkg::STATUS_HIT;
      out_next.entry_index   = found_idx_ext[6:0];
      out_next.msg_total     = found_cnt;
      out_next.active_count  = occ_ext[7:0];
    end else if (room) begin
      out_next.status        = ftwa_pkg::STATUS_NEW;
      out_next.entry_index   = occ_ext[6:0];
      out_next.msg_total     = 32'd1;
      out_next.active_count  = occ_inc_ext[7:0];
    end else begin
      out_next.status        = ftwa_pkg::STATUS_FULL;
      out_next.active_count  = occ_ext[7:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= out_next;
    end
  end

endmodule

/* rtl/core/flow_table_with_aging_unit.sv */
// Top level of the flow table with idle-timeout aging.
// Input channel (in_valid/in_ready/in_data) carries one item per handshake:
// a lookup (command 0) finds the flow by address and port from entry 0 up,
// refreshes its time stamp and bumps its saturating count, or appends it
// when absent and there is room, or rejects it when the table is full. A
// sweep (command 1) drops every entry idle longer than idle_timeout and
// compacts the survivors in order.
// Output channel (out_valid/out_ready/out_data) returns one item per input.
// out_valid is set by the walk over the entry memory, in order: one entry
// read per cycle from entry 0 up to the occupancy count, each read registered
// and then evaluated, the controller sees the walk drained, and the result is
// posted into the output register. A hit at entry i ends the walk early.
// One item is in work at a time; in_ready is high only while no item is in
// work, so a new item is not taken before the last one's result is posted.
// A stalled receiver holds the result in the output register; the next item
// may be taken and walked meanwhile, but its result waits until the register
// frees up.
// Reset clears the occupancy count and loads idle_timeout with 300; the entry
// memory is not cleared, since only entries below the count are ever read.
// cfg_wr_en/cfg_wr_data write idle_timeout; write only while idle.
module flow_table_with_aging_unit #(
  parameter int unsigned TABLE_DEPTH = ftwa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ftwa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ftwa_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [16:0]         cfg_wr_data
);

  ftwa_pkg::ctl_cmd_t cmd;
  ftwa_pkg::dp_stat_t stat;

  // Sequence load, walk and finish
  ftwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the table, walk it and post the result
  ftwa_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
